FILE: sv/scene_text_tokenizer_macros.svh
// Assertion macros shared by the tokenizer modules.
// Each macro checks on the rising clock edge and is disabled while reset is asserted.
`ifndef SCENE_TEXT_TOKENIZER_MACROS_SVH
`define SCENE_TEXT_TOKENIZER_MACROS_SVH

// The property must hold at every edge outside reset.
`define STT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tokenizer check failed");

// Whenever the condition holds, the property must hold in the following cycle.
`define STT_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("tokenizer check failed");

`endif

FILE: sv/stt_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and character class functions for the scene text tokenizer.
// This package has no dependencies.
package stt_pkg;

  localparam int unsigned MaxWordChars   = 255;
  localparam int unsigned MaxNumberChars = 63;
  localparam int unsigned QueueDepth     = 4;

  // Event kinds.
  localparam logic [2:0] EvChar   = 3'd0;
  localparam logic [2:0] EvEnd    = 3'd1;
  localparam logic [2:0] EvLbrace = 3'd2;
  localparam logic [2:0] EvRbrace = 3'd3;
  localparam logic [2:0] EvEof    = 3'd4;
  localparam logic [2:0] EvError  = 3'd5;

  // Token classes.
  localparam logic [1:0] ClsIdent  = 2'd0;
  localparam logic [1:0] ClsString = 2'd1;
  localparam logic [1:0] ClsNumber = 2'd2;

  // Special characters.
  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChNl     = 8'h0a;
  localparam logic [7:0] ChSlash  = 8'h2f;
  localparam logic [7:0] ChLbrace = 8'h7b;
  localparam logic [7:0] ChRbrace = 8'h7d;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChUnder  = 8'h5f;
  localparam logic [7:0] ChMinus  = 8'h2d;
  localparam logic [7:0] ChDot    = 8'h2e;

  typedef struct packed {
    logic [2:0] event_kind;
    logic [1:0] token_class;
    logic [7:0] char_value;
    logic       first_char;
    logic       run_last;
  } stt_result_t;

  // Up to two results written into the output queue in the same cycle.
  typedef struct packed {
    logic [1:0]  n;
    stt_result_t r0;
    stt_result_t r1;
  } stt_push_t;

  function automatic logic is_letter(logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return b == 8'h20 || (b >= 8'h09 && b <= 8'h0d);
  endfunction

  function automatic logic ident_body(logic [7:0] b);
    return is_letter(b) || is_digit(b) || b == ChUnder;
  endfunction

  function automatic logic number_body(logic [7:0] b);
    return is_digit(b) || b == ChMinus || b == ChDot;
  endfunction

  function automatic stt_result_t mk_result(logic [2:0] kind, logic [1:0] cls,
                                            logic [7:0] ch, logic first);
    stt_result_t r;
    r.event_kind  = kind;
    r.token_class = cls;
    r.char_value  = ch;
    r.first_char  = first;
    r.run_last    = 1'b0;
    return r;
  endfunction

endpackage

FILE: sv/stt_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the text input and the token event output.
// These interfaces have no dependencies.
interface stt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

interface stt_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_kind;
  logic [1:0] token_class;
  logic [7:0] char_value;
  logic       first_char;
  logic       run_last;

  modport source (output valid, output event_kind, output token_class, output char_value,
                  output first_char, output run_last, input ready);
  modport sink (input valid, input event_kind, input token_class, input char_value,
                input first_char, input run_last, output ready);
endinterface

FILE: sv/stt_scan.sv
`timescale 1ns / 1ps
// Scanner core: mode and token length registers plus the per-byte decode.
// Depends on stt_pkg and scene_text_tokenizer_macros.svh.
`include "scene_text_tokenizer_macros.svh"
module stt_scan #(
  parameter int unsigned MaxWordChars   = stt_pkg::MaxWordChars,
  parameter int unsigned MaxNumberChars = stt_pkg::MaxNumberChars
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        byte_i,
  output stt_pkg::stt_push_t push_o
);
  import stt_pkg::*;

  localparam int unsigned MaxChars =
      (MaxWordChars > MaxNumberChars) ? MaxWordChars : MaxNumberChars;
  localparam int unsigned LenW = $clog2(MaxChars + 1);
  localparam logic [LenW-1:0] WordLimit   = LenW'(MaxWordChars);
  localparam logic [LenW-1:0] NumberLimit = LenW'(MaxNumberChars);

  localparam logic [2:0] ModeIdle    = 3'd0;
  localparam logic [2:0] ModeComment = 3'd1;
  localparam logic [2:0] ModeSlash   = 3'd2;
  localparam logic [2:0] ModeIdent   = 3'd3;
  localparam logic [2:0] ModeString  = 3'd4;
  localparam logic [2:0] ModeNumber  = 3'd5;
  localparam logic [2:0] ModeError   = 3'd6;

  logic [2:0]      mode_q, mode_d;
  logic [LenW-1:0] len_q, len_d;

  // Handling of a byte between tokens.
  logic            idle_emit;
  stt_result_t     idle_res;
  logic [2:0]      idle_mode;
  logic            idle_start;

  logic [1:0]      n;
  stt_result_t     r0, r1;
  logic            run_num;
  logic            in_class;
  logic [LenW-1:0] limit;

  always_comb begin
    idle_emit  = 1'b0;
    idle_res   = mk_result(EvEof, ClsIdent, ChNul, 1'b0);
    idle_mode  = ModeIdle;
    idle_start = 1'b0;
    if (byte_i == ChNul) begin
      idle_emit = 1'b1;
    end else if (is_space(byte_i)) begin
      idle_emit = 1'b0;
    end else if (byte_i == ChSlash) begin
      idle_mode = ModeSlash;
    end else if (byte_i == ChLbrace) begin
      idle_emit = 1'b1;
      idle_res  = mk_result(EvLbrace, ClsIdent, ChNul, 1'b0);
    end else if (byte_i == ChRbrace) begin
      idle_emit = 1'b1;
      idle_res  = mk_result(EvRbrace, ClsIdent, ChNul, 1'b0);
    end else if (byte_i == ChQuote) begin
      idle_mode = ModeString;
    end else if (is_letter(byte_i) || byte_i == ChUnder) begin
      idle_emit  = 1'b1;
      idle_res   = mk_result(EvChar, ClsIdent, byte_i, 1'b1);
      idle_mode  = ModeIdent;
      idle_start = 1'b1;
    end else if (number_body(byte_i)) begin
      idle_emit  = 1'b1;
      idle_res   = mk_result(EvChar, ClsNumber, byte_i, 1'b1);
      idle_mode  = ModeNumber;
      idle_start = 1'b1;
    end else begin
      idle_emit = 1'b1;
      idle_res  = mk_result(EvError, ClsIdent, ChNul, 1'b0);
      idle_mode = ModeError;
    end
  end

  always_comb begin
    run_num  = (mode_q == ModeNumber);
    in_class = run_num ? number_body(byte_i) : ident_body(byte_i);
    limit    = run_num ? NumberLimit : WordLimit;
    n        = 2'd0;
    r0       = mk_result(EvChar, ClsIdent, ChNul, 1'b0);
    r1       = r0;
    mode_d   = mode_q;
    len_d    = len_q;
    unique case (mode_q)
      ModeComment: begin
        if (byte_i == ChNl) begin
          mode_d = ModeIdle;
        end else if (byte_i == ChNul) begin
          n      = 2'd1;
          r0     = idle_res;
          mode_d = ModeIdle;
          len_d  = '0;
        end
      end
      ModeSlash: begin
        if (byte_i == ChSlash) begin
          mode_d = ModeComment;
        end else begin
          n      = 2'd1;
          r0     = mk_result(EvError, ClsIdent, ChNul, 1'b0);
          mode_d = ModeError;
          if (byte_i == ChNul) begin
            n      = 2'd2;
            r1     = idle_res;
            mode_d = ModeIdle;
            len_d  = '0;
          end
        end
      end
      ModeIdent, ModeNumber: begin
        if (in_class && len_q < limit) begin
          n     = 2'd1;
          r0    = mk_result(EvChar, run_num ? ClsNumber : ClsIdent, byte_i, 1'b0);
          len_d = len_q + LenW'(1);
        end else begin
          // Close the token, then treat the byte as if between tokens.
          n      = idle_emit ? 2'd2 : 2'd1;
          r0     = mk_result(EvEnd, run_num ? ClsNumber : ClsIdent, ChNul, 1'b0);
          r1     = idle_res;
          mode_d = idle_mode;
          len_d  = idle_start ? LenW'(1) : '0;
        end
      end
      ModeString: begin
        if (byte_i == ChQuote) begin
          n      = 2'd1;
          r0     = mk_result(EvEnd, ClsString, ChNul, 1'b0);
          mode_d = ModeIdle;
          len_d  = '0;
        end else if (byte_i != ChNul && len_q < WordLimit) begin
          n     = 2'd1;
          r0    = mk_result(EvChar, ClsString, byte_i, len_q == '0);
          len_d = len_q + LenW'(1);
        end else begin
          n      = idle_emit ? 2'd2 : 2'd1;
          r0     = mk_result(EvEnd, ClsString, ChNul, 1'b0);
          r1     = idle_res;
          mode_d = idle_mode;
          len_d  = idle_start ? LenW'(1) : '0;
        end
      end
      ModeError: begin
        if (byte_i == ChNul) begin
          n      = 2'd1;
          r0     = idle_res;
          mode_d = ModeIdle;
          len_d  = '0;
        end
      end
      default: begin
        n      = idle_emit ? 2'd1 : 2'd0;
        r0     = idle_res;
        mode_d = idle_mode;
        len_d  = idle_start ? LenW'(1) : '0;
      end
    endcase
    if (n == 2'd2) begin
      r1.run_last = 1'b1;
    end else begin
      r0.run_last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      len_q  <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      len_q  <= len_d;
    end
  end

  assign push_o.n  = accept_i ? n : 2'd0;
  assign push_o.r0 = r0;
  assign push_o.r1 = r1;

  `STT_ASSERT(a_pair_head, clk_i, rst_ni, push_o.n == 2'd2 |-> (push_o.r0.event_kind == EvEnd || push_o.r0.event_kind == EvError))
  `STT_ASSERT_NEXT(a_nul_idle, clk_i, rst_ni, accept_i && byte_i == ChNul, mode_q == ModeIdle && len_q == '0)
  `STT_ASSERT(a_len_bound, clk_i, rst_ni, len_q <= LenW'(MaxChars))

endmodule

FILE: sv/stt_outq.sv
`timescale 1ns / 1ps
// Small result queue: takes up to two results per cycle and hands out one.
// Depends on stt_pkg and scene_text_tokenizer_macros.svh.
`include "scene_text_tokenizer_macros.svh"
module stt_outq #(
  parameter int unsigned Depth = stt_pkg::QueueDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  stt_pkg::stt_push_t   push_i,
  output logic                 room_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output stt_pkg::stt_result_t out_data_o
);
  import stt_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  stt_result_t     mem_q [Depth];
  logic [PtrW-1:0] head_q, head_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PtrW-1:0] tail;
  logic            pop;

  assign tail        = head_q + cnt_q[PtrW-1:0];
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[head_q];
  assign pop         = out_valid_o && out_ready_i;
  // Room for the worst case of two results from the next byte.
  assign room_o      = (cnt_q <= CntW'(Depth - 2));

  always_comb begin
    head_d = pop ? head_q + PtrW'(1) : head_q;
    cnt_d  = cnt_q + CntW'(push_i.n) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[tail] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[tail + PtrW'(1)] <= push_i.r1;
    end
  end

  `STT_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CntW'(Depth))
  `STT_ASSERT(a_push_room, clk_i, rst_ni, push_i.n != 2'd0 |-> room_o)
  `STT_ASSERT_NEXT(a_pop_only, clk_i, rst_ni, pop && push_i.n == 2'd0, cnt_q == $past(cnt_q) - CntW'(1))

endmodule

FILE: sv/scene_text_tokenizer.sv
`timescale 1ns / 1ps
// Scene text tokenizer top level. The events of an accepted byte are registered into the
// result queue and offered from its head. Throughput: one byte per cycle while each byte
// yields at most one event and the consumer is ready; the single-event output port sets
// the limit, and a byte that yields two events is absorbed by a four-entry result queue.
// Reset: asynchronous and active low; the scanner returns to idle and the queue empties.
module scene_text_tokenizer #(
  parameter int unsigned MAX_WORD_CHARS   = stt_pkg::MaxWordChars,
  parameter int unsigned MAX_NUMBER_CHARS = stt_pkg::MaxNumberChars
) (
  input logic         clk_i,
  input logic         rst_ni,
  stt_in_if.sink      text_i,
  stt_out_if.source   event_o
);
  import stt_pkg::*;

  // The scanner decodes each accepted byte against its mode and token length in the
  // same cycle and writes zero, one or two events into the queue. The queue holds the
  // events until the consumer takes them, so a stalled consumer never blocks a byte
  // while there is still room for the worst case of two events.
  stt_push_t   push;
  stt_result_t head;
  logic        room;
  logic        accept;

  assign text_i.ready = room;
  assign accept       = text_i.valid && room;

  stt_scan #(
    .MaxWordChars  (MAX_WORD_CHARS),
    .MaxNumberChars(MAX_NUMBER_CHARS)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .byte_i  (text_i.text_byte),
    .push_o  (push)
  );

  stt_outq #(
    .Depth(QueueDepth)
  ) u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .room_o     (room),
    .out_valid_o(event_o.valid),
    .out_ready_i(event_o.ready),
    .out_data_o (head)
  );

  // The event fields come straight from the queue head entry.
  assign event_o.event_kind  = head.event_kind;
  assign event_o.token_class = head.token_class;
  assign event_o.char_value  = head.char_value;
  assign event_o.first_char  = head.first_char;
  assign event_o.run_last    = head.run_last;

endmodule
